/* rtl/qdacq_pkg.sv */
// Package for the quadrant dead-zone AC quantizer.
// Stream field layout, fixed-point constants and the threshold function.
// No dependencies; used by quadrant_deadzone_ac_quantizer_unit.
`default_nettype none

package qdacq_pkg;

  // stream widths
  localparam int unsigned SDataW = 96;
  localparam int unsigned SUserW = 2;
  localparam int unsigned MDataW = 32;
  localparam int unsigned MUserW = 1;

  // field widths
  localparam int unsigned CoefW  = 32;
  localparam int unsigned WgtW   = 24;
  localparam int unsigned RqW    = 9;
  localparam int unsigned ChanW  = 2;
  localparam int unsigned BlkW   = 7;
  localparam int unsigned PosW   = 5;
  localparam int unsigned SizeW  = 6;
  localparam int unsigned GsW    = 32;
  localparam int unsigned MmW    = 16;
  localparam int unsigned CfgW   = 32;

  // fixed-point layout of the scaled product
  localparam int unsigned FracBits = 60;
  localparam int unsigned ThW      = 16;
  localparam int unsigned ProdW    = 113;
  localparam int unsigned IpW      = ProdW - FracBits;

  // configuration register indexes
  localparam logic CfgIdxScale = 1'b0;
  localparam logic CfgIdxMult  = 1'b1;

  localparam logic [GsW-1:0] GsReset = 32'd65536;
  localparam logic [MmW-1:0] MmReset = 16'd4096;

  // channel codes
  localparam logic [ChanW-1:0] ChanY = 2'd1;

  // thresholds, unsigned Q0.16
  localparam logic [ThW-1:0] ThBase0 = 16'd38011;
  localparam logic [ThW-1:0] ThY     = 16'd41943;
  localparam logic [ThW-1:0] ThXb    = 16'd40632;
  localparam logic [ThW-1:0] ThStep  = 16'd488;
  localparam logic [ThW-1:0] ThFloor = 16'd32768;
  localparam logic [BlkW-1:0] ThMinBlocks = 7'd4;

  localparam logic [CoefW-1:0] SatPos = 32'h7FFF_FFFF;
  localparam logic [CoefW-1:0] SatNeg = 32'h8000_0000;

  // Quadrant threshold. Non-Y channels covering four or more blocks get the
  // lowered threshold, clamped at the floor.
  function automatic logic [ThW-1:0] pick_threshold(
    input logic [ChanW-1:0] chan,
    input logic [BlkW-1:0]  blocks,
    input logic             upper_row,
    input logic             upper_col
  );
    logic [ThW-1:0] base;
    logic [ThW-1:0] step;
    logic [ThW-1:0] th;
    base = (!upper_row && !upper_col) ? ThBase0 : ((chan == ChanY) ? ThY : ThXb);
    // 488 * 127 still fits in 16 bits
    step = ThStep * ThW'(blocks);
    th   = base;
    if (chan != ChanY && blocks >= ThMinBlocks) begin
      if (step > (base - ThFloor)) begin
        th = ThFloor;
      end else begin
        th = base - step;
      end
    end
    return th;
  endfunction

endpackage

`default_nettype wire

/* rtl/quadrant_deadzone_ac_quantizer_unit.sv */
// Quadrant dead-zone AC quantizer, top level: six-stage multiply pipeline.
// Depends on qdacq_pkg for field widths, constants and the threshold function.
//
// Usage: one transform coefficient per beat on the s_axis group, one quantized
// value per beat on the m_axis group, in order. The coefficient is scaled by
// weight * global scale * raw quant * matrix multiplier, held exactly with 60
// fractional bits; a magnitude under the quadrant threshold gives zero, any
// other is rounded half to even and saturated to int32 (overflow in tuser).
// Throughput: one beat per cycle while the sink is ready; the 113-bit product
// is built from partial products of 32-bit slices over three multiplier stages,
// then summed, rounded and saturated in three more stages.
// Stall: all stages share one advance enable (output empty or taken), so a
// stalled sink freezes the pipe and s_axis_tready drops; nothing is lost or
// duplicated. The output stage is the output register.
// Configuration: cfg_we_i writes the global scale (index 0) or the matrix
// multiplier (index 1); write only while the pipe is empty.
// Reset: empties the pipe and restores both the scale and the multiplier
// to 1.0.
`default_nettype none

module quadrant_deadzone_ac_quantizer_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_idx_i,
  input  wire logic [qdacq_pkg::CfgW-1:0]    cfg_wdata_i,
  // coefficient input
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // coefficient[31:0], weight[55:32], quant[64:56], blocks[71:65],
  // column[76:72], row[81:77], block_width[87:82], block_height[93:88], zero pad
  input  wire logic [qdacq_pkg::SDataW-1:0]  s_axis_tdata,
  // channel[1:0]
  input  wire logic [qdacq_pkg::SUserW-1:0]  s_axis_tuser,
  input  wire logic                          s_axis_tlast,
  // quantized output
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // quantized_value[31:0]
  output logic [qdacq_pkg::MDataW-1:0]       m_axis_tdata,
  // overflow[0]
  output logic [qdacq_pkg::MUserW-1:0]       m_axis_tuser,
  output logic                               m_axis_tlast
);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [qdacq_pkg::GsW-1:0] gscale_q;
  logic [qdacq_pkg::MmW-1:0] mmult_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gscale_q <= qdacq_pkg::GsReset;
      mmult_q  <= qdacq_pkg::MmReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == qdacq_pkg::CfgIdxScale) begin
        gscale_q <= cfg_wdata_i;
      end else begin
        mmult_q <= cfg_wdata_i[qdacq_pkg::MmW-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input field unpack
  // ---------------------------------------------------------------------------
  logic [qdacq_pkg::CoefW-1:0] in_coef;
  logic [qdacq_pkg::WgtW-1:0]  in_wgt;
  logic [qdacq_pkg::RqW-1:0]   in_rq;
  logic [qdacq_pkg::BlkW-1:0]  in_blk;
  logic [qdacq_pkg::PosW-1:0]  in_col;
  logic [qdacq_pkg::PosW-1:0]  in_row;
  logic [qdacq_pkg::SizeW-1:0] in_bw;
  logic [qdacq_pkg::SizeW-1:0] in_bh;

  assign in_coef = s_axis_tdata[31:0];
  assign in_wgt  = s_axis_tdata[55:32];
  assign in_rq   = s_axis_tdata[64:56];
  assign in_blk  = s_axis_tdata[71:65];
  assign in_col  = s_axis_tdata[76:72];
  assign in_row  = s_axis_tdata[81:77];
  assign in_bw   = s_axis_tdata[87:82];
  assign in_bh   = s_axis_tdata[93:88];

  // one advance enable for the whole pipe
  logic adv;
  logic s_acc;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign s_acc         = s_axis_tvalid && adv;

  // ---------------------------------------------------------------------------
  // stage 1: sign/magnitude, threshold, weight*scale, quant*multiplier
  // ---------------------------------------------------------------------------
  logic                        s1_vld_q;
  logic [55:0]                 s1_a_q, s1_a_d;
  logic [24:0]                 s1_p_q, s1_p_d;
  logic [31:0]                 s1_mag_q, s1_mag_d;
  logic [qdacq_pkg::ThW-1:0]   s1_th_q, s1_th_d;
  logic                        s1_neg_q, s1_last_q;

  always_comb begin
    s1_a_d   = 56'(in_wgt) * 56'(gscale_q);
    s1_p_d   = 25'(in_rq) * 25'(mmult_q);
    s1_mag_d = in_coef[31] ? (~in_coef + 32'd1) : in_coef;
    s1_th_d  = qdacq_pkg::pick_threshold(s_axis_tuser, in_blk,
                 (in_row >= 5'(in_bh >> 1)), (in_col >= 5'(in_bw >> 1)));
  end

  // ---------------------------------------------------------------------------
  // stage 2: b = quant*multiplier*magnitude
  // ---------------------------------------------------------------------------
  logic                        s2_vld_q;
  logic [55:0]                 s2_a_q;
  logic [56:0]                 s2_b_q;
  logic [qdacq_pkg::ThW-1:0]   s2_th_q;
  logic                        s2_neg_q, s2_last_q;

  // ---------------------------------------------------------------------------
  // stage 3: four partial products of 32-bit slices of a*b
  // ---------------------------------------------------------------------------
  logic                        s3_vld_q;
  logic [63:0]                 s3_p00_q;
  logic [56:0]                 s3_p01_q;
  logic [55:0]                 s3_p10_q;
  logic [48:0]                 s3_p11_q;
  logic [qdacq_pkg::ThW-1:0]   s3_th_q;
  logic                        s3_neg_q, s3_last_q;

  // ---------------------------------------------------------------------------
  // stage 4: full product
  // ---------------------------------------------------------------------------
  logic                        s4_vld_q;
  logic [qdacq_pkg::ProdW-1:0] s4_prod_q, s4_prod_d;
  logic [qdacq_pkg::ThW-1:0]   s4_th_q;
  logic                        s4_neg_q, s4_last_q;

  logic [57:0] s4_mid;
  always_comb begin
    s4_mid    = 58'(s3_p01_q) + 58'(s3_p10_q);
    s4_prod_d = {s3_p11_q, 64'd0}
              + (qdacq_pkg::ProdW'(s4_mid) << 32)
              + qdacq_pkg::ProdW'(s3_p00_q);
  end

  // ---------------------------------------------------------------------------
  // stage 5: dead-zone test and round-half-even decision
  // ---------------------------------------------------------------------------
  logic                        s5_vld_q;
  logic [qdacq_pkg::IpW-1:0]   s5_ip_q;
  logic                        s5_rnd_q, s5_rnd_d;
  logic                        s5_zero_q, s5_zero_d;
  logic                        s5_neg_q, s5_last_q;

  logic [qdacq_pkg::FracBits-1:0] s5_frac;
  logic [qdacq_pkg::IpW-1:0]      s5_ip;
  always_comb begin
    s5_ip     = s4_prod_q[qdacq_pkg::ProdW-1:qdacq_pkg::FracBits];
    s5_frac   = s4_prod_q[qdacq_pkg::FracBits-1:0];
    // threshold is below 1.0, so only the fraction needs the compare
    s5_zero_d = (s5_ip == '0) &&
                (s5_frac < {s4_th_q, (qdacq_pkg::FracBits - qdacq_pkg::ThW)'(0)});
    s5_rnd_d  = s5_frac[qdacq_pkg::FracBits-1] &&
                ((s5_frac[qdacq_pkg::FracBits-2:0] != '0) || s5_ip[0]);
  end

  // ---------------------------------------------------------------------------
  // stage 6 (output register): round, saturate, restore sign
  // ---------------------------------------------------------------------------
  logic                        s6_vld_q;
  logic [qdacq_pkg::CoefW-1:0] s6_val_q, s6_val_d;
  logic                        s6_ovf_q, s6_ovf_d;
  logic                        s6_last_q;

  logic [qdacq_pkg::IpW:0] s6_ipr;
  always_comb begin
    s6_ipr   = (qdacq_pkg::IpW+1)'(s5_ip_q) + (qdacq_pkg::IpW+1)'(s5_rnd_q);
    s6_val_d = '0;
    s6_ovf_d = 1'b0;
    if (!s5_zero_q) begin
      if (!s5_neg_q) begin
        if (s6_ipr > (qdacq_pkg::IpW+1)'(qdacq_pkg::SatPos)) begin
          s6_val_d = qdacq_pkg::SatPos;
          s6_ovf_d = 1'b1;
        end else begin
          s6_val_d = s6_ipr[31:0];
        end
      end else begin
        if (s6_ipr > (qdacq_pkg::IpW+1)'(qdacq_pkg::SatNeg)) begin
          s6_val_d = qdacq_pkg::SatNeg;
          s6_ovf_d = 1'b1;
        end else begin
          s6_val_d = ~s6_ipr[31:0] + 32'd1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // valid bits
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= s_axis_tvalid;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
      s6_vld_q <= s5_vld_q;
    end
  end

  // ---------------------------------------------------------------------------
  // payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_a_q    <= s1_a_d;
      s1_p_q    <= s1_p_d;
      s1_mag_q  <= s1_mag_d;
      s1_th_q   <= s1_th_d;
      s1_neg_q  <= in_coef[31];
      s1_last_q <= s_axis_tlast;

      s2_a_q    <= s1_a_q;
      s2_b_q    <= 57'(s1_p_q) * 57'(s1_mag_q);
      s2_th_q   <= s1_th_q;
      s2_neg_q  <= s1_neg_q;
      s2_last_q <= s1_last_q;

      s3_p00_q  <= 64'(s2_a_q[31:0])  * 64'(s2_b_q[31:0]);
      s3_p01_q  <= 57'(s2_a_q[31:0])  * 57'(s2_b_q[56:32]);
      s3_p10_q  <= 56'(s2_a_q[55:32]) * 56'(s2_b_q[31:0]);
      s3_p11_q  <= 49'(s2_a_q[55:32]) * 49'(s2_b_q[56:32]);
      s3_th_q   <= s2_th_q;
      s3_neg_q  <= s2_neg_q;
      s3_last_q <= s2_last_q;

      s4_prod_q <= s4_prod_d;
      s4_th_q   <= s3_th_q;
      s4_neg_q  <= s3_neg_q;
      s4_last_q <= s3_last_q;

      s5_ip_q   <= s5_ip;
      s5_rnd_q  <= s5_rnd_d;
      s5_zero_q <= s5_zero_d;
      s5_neg_q  <= s4_neg_q;
      s5_last_q <= s4_last_q;

      s6_val_q  <= s6_val_d;
      s6_ovf_q  <= s6_ovf_d;
      s6_last_q <= s5_last_q;
    end
  end

  assign m_axis_tvalid = s6_vld_q;
  assign m_axis_tdata  = s6_val_q;
  assign m_axis_tuser  = s6_ovf_q;
  assign m_axis_tlast  = s6_last_q;

`ifndef ASSERT_OFF
  // saturation flag only ever comes with a rail value
  a_ovf_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |->
      (m_axis_tdata == qdacq_pkg::SatPos || m_axis_tdata == qdacq_pkg::SatNeg))
    else $error("overflow flag without saturated value");

  // an accepted beat lands in the first stage
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> s1_vld_q)
    else $error("accepted beat lost at pipe entry");

  // a dead-zone hit leaves the pipe as zero with no overflow
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s5_vld_q && s5_zero_q) |=> (m_axis_tdata == '0 && !m_axis_tuser[0]))
    else $error("dead-zone item not zero at output");
`endif

endmodule

`default_nettype wire
